// ===== rtl/core/hwfr_pkg.sv =====
// Shared types, codes and constants of the haptic wall force renderer.
// Holds the decay weight table used by the top-level datapath.
// No dependencies; compile this file first.
package hwfr_pkg;

    typedef enum logic [1:0] {
        KIND_POS   = 2'd0,
        KIND_FORCE = 2'd1,
        KIND_DELTA = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // Wall axis codes; the unused fourth code behaves as z.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_STIFFNESS = 2'd0;
    localparam logic [1:0] REG_WALL_POS  = 2'd1;
    localparam logic [1:0] REG_WALL_AXIS = 2'd2;

    localparam int POS_W      = 18;
    localparam int CMD_W      = 16;
    localparam int FORCE_W    = 16;
    localparam int STIFF_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int AF_W       = 12;
    localparam int AD_W       = 11;
    localparam int PH_W       = 16;
    localparam int FRAC_W     = 10;
    localparam int WEIGHT_W   = 17;

    localparam logic [STIFF_W-1:0]      STIFF_RESET = 16'd1000;
    localparam logic signed [POS_W-1:0] WALL_RESET  = 18'sd8520;

    localparam logic signed [CMD_W-1:0] FORCE_LIMIT = 16'sd1536;
    localparam logic signed [16:0]      DELTA_LIMIT = 17'sd768;

    // Phase of one full decay, in 2^-15 units.
    localparam int PHASE_ONE = 32768;

    // Centering divide by 12800: offset keeps the dividend positive, then a
    // reciprocal multiply divides by 50 exactly for dividends below 2^27.
    localparam logic signed [35:0] DIV_OFFSET = 36'sd13421779200;
    localparam logic signed [23:0] DIV_BIAS   = 24'sd1048576;
    localparam logic [27:0]        DIV_RECIP  = 28'd171798692;
    localparam int                 DIV_SHIFT  = 33;

    typedef struct packed {
        t_kind                    kind;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic                     button;
        logic signed [CMD_W-1:0]  cmd_x;
        logic signed [CMD_W-1:0]  cmd_y;
        logic signed [CMD_W-1:0]  cmd_z;
    } t_in_item;

    typedef struct packed {
        logic [STIFF_W-1:0]       stiffness;
        logic signed [POS_W-1:0]  wall_position;
        logic [1:0]               wall_axis;
    } t_cfg;

    // What one processed beat hands to the arithmetic pipeline.
    typedef struct packed {
        logic                       produce;
        logic [1:0]                 axis;
        logic                       in_wall;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic signed [POS_W:0]      pos_off;
        logic [2:0][AF_W-1:0]       act_force;
        logic [2:0][AD_W-1:0]       act_delta;
        logic [PH_W-1:0]            phase;
    } t_step;

    // Raised-cosine decay weight, Q1.15, 33 points over one decay.
    function automatic logic [WEIGHT_W-1:0] weight_rom(input logic [5:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            6'd0:    w = 17'd32768;
            6'd1:    w = 17'd32689;
            6'd2:    w = 17'd32453;
            6'd3:    w = 17'd32063;
            6'd4:    w = 17'd31521;
            6'd5:    w = 17'd30833;
            6'd6:    w = 17'd30007;
            6'd7:    w = 17'd29049;
            6'd8:    w = 17'd27969;
            6'd9:    w = 17'd26778;
            6'd10:   w = 17'd25486;
            6'd11:   w = 17'd24107;
            6'd12:   w = 17'd22654;
            6'd13:   w = 17'd21140;
            6'd14:   w = 17'd19580;
            6'd15:   w = 17'd17990;
            6'd16:   w = 17'd16384;
            6'd17:   w = 17'd14778;
            6'd18:   w = 17'd13188;
            6'd19:   w = 17'd11628;
            6'd20:   w = 17'd10114;
            6'd21:   w = 17'd8661;
            6'd22:   w = 17'd7282;
            6'd23:   w = 17'd5990;
            6'd24:   w = 17'd4799;
            6'd25:   w = 17'd3719;
            6'd26:   w = 17'd2761;
            6'd27:   w = 17'd1935;
            6'd28:   w = 17'd1247;
            6'd29:   w = 17'd705;
            6'd30:   w = 17'd315;
            6'd31:   w = 17'd79;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/hwfr_if.sv =====
// Handshake channel interfaces of the haptic wall force renderer:
// input items, result items and configuration writes.
// Depends on hwfr_pkg for field widths.
interface hwfr_in_if;
    import hwfr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic                     button;
    logic signed [CMD_W-1:0]  cmd_x;
    logic signed [CMD_W-1:0]  cmd_y;
    logic signed [CMD_W-1:0]  cmd_z;

    modport source (output valid, kind, pos_x, pos_y, pos_z, button, cmd_x, cmd_y, cmd_z,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pos_z, button, cmd_x, cmd_y, cmd_z,
                    output ready);
endinterface

interface hwfr_out_if;
    import hwfr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FORCE_W-1:0]  force_x;
    logic signed [FORCE_W-1:0]  force_y;
    logic signed [FORCE_W-1:0]  force_z;

    modport source (output valid, force_x, force_y, force_z, input ready);
    modport sink   (input valid, force_x, force_y, force_z, output ready);
endinterface

interface hwfr_cfg_if;
    import hwfr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/core/hwfr_servo_ctrl.sv =====
// Servo state of the wall renderer: initialization, button handling,
// pending and active commands, and the decay phase counter.
// Depends on hwfr_pkg.
module hwfr_servo_ctrl #(
    parameter int DECAY_STEPS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  hwfr_pkg::t_in_item i_item,
    input  hwfr_pkg::t_cfg     i_cfg,
    output hwfr_pkg::t_step    o_step
);
    import hwfr_pkg::*;

    localparam int T_W   = $clog2(DECAY_STEPS + 1);
    localparam int REM_W = $clog2(DECAY_STEPS);
    localparam logic [T_W-1:0]  T_MAX    = T_W'(DECAY_STEPS);
    localparam logic [PH_W-1:0] PH_STEP  = PH_W'(PHASE_ONE / DECAY_STEPS);
    localparam logic [REM_W:0]  REM_STEP = (REM_W + 1)'(PHASE_ONE % DECAY_STEPS);
    localparam logic [REM_W:0]  REM_MOD  = (REM_W + 1)'(DECAY_STEPS);

    logic                    r_init, n_init;
    logic                    r_push_pos, n_push_pos;
    logic                    r_held, n_held;
    logic                    r_force_wait, n_force_wait;
    logic                    r_delta_wait, n_delta_wait;
    logic signed [CMD_W-1:0] r_pend_force [3];
    logic signed [CMD_W-1:0] n_pend_force [3];
    logic signed [CMD_W-1:0] r_pend_delta [3];
    logic signed [CMD_W-1:0] n_pend_delta [3];
    logic signed [AF_W-1:0]  r_act_force [3];
    logic signed [AF_W-1:0]  n_act_force [3];
    logic signed [AD_W-1:0]  r_act_delta [3];
    logic signed [AD_W-1:0]  n_act_delta [3];
    logic [T_W-1:0]          r_elapsed, n_elapsed;
    logic [PH_W-1:0]         r_phase, n_phase;
    logic [REM_W-1:0]        r_rem, n_rem;

    logic [1:0]              axis;
    logic signed [POS_W-1:0] pos_a;
    logic                    above, below, in_wall, left_wall, produce;
    logic [REM_W:0]          rem_sum;
    logic signed [CMD_W-1:0] cmd [3];

    function automatic logic signed [AF_W-1:0] clamp_force(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] c;
        if (v > FORCE_LIMIT) begin
            c = FORCE_LIMIT;
        end else if (v < -FORCE_LIMIT) begin
            c = -FORCE_LIMIT;
        end else begin
            c = v;
        end
        return c[AF_W-1:0];
    endfunction

    // Halve with rounding toward +infinity, then limit to 3 N.
    function automatic logic signed [AD_W-1:0] clamp_delta(input logic signed [CMD_W-1:0] v);
        logic signed [16:0] h;
        h = (17'(v) + 17'sd1) >>> 1;
        if (h > DELTA_LIMIT) begin
            h = DELTA_LIMIT;
        end else if (h < -DELTA_LIMIT) begin
            h = -DELTA_LIMIT;
        end
        return h[AD_W-1:0];
    endfunction

    always_comb begin
        axis = (i_cfg.wall_axis == AXIS_X || i_cfg.wall_axis == AXIS_Y) ?
               i_cfg.wall_axis : AXIS_Z;
        case (axis)
            AXIS_X:  pos_a = i_item.pos_x;
            AXIS_Y:  pos_a = i_item.pos_y;
            default: pos_a = i_item.pos_z;
        endcase
        above     = pos_a > i_cfg.wall_position;
        below     = pos_a < i_cfg.wall_position;
        in_wall   = (below && r_push_pos) || (above && !r_push_pos);
        left_wall = (above && r_push_pos) || (below && !r_push_pos);
        cmd[0]    = i_item.cmd_x;
        cmd[1]    = i_item.cmd_y;
        cmd[2]    = i_item.cmd_z;
        rem_sum   = {1'b0, r_rem} + REM_STEP;
    end

    always_comb begin
        n_init       = r_init;
        n_push_pos   = r_push_pos;
        n_held       = r_held;
        n_force_wait = r_force_wait;
        n_delta_wait = r_delta_wait;
        n_elapsed    = r_elapsed;
        n_phase      = r_phase;
        n_rem        = r_rem;
        produce      = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_pend_force[i] = r_pend_force[i];
            n_pend_delta[i] = r_pend_delta[i];
            n_act_force[i]  = r_act_force[i];
            n_act_delta[i]  = r_act_delta[i];
        end

        case (i_item.kind)
            KIND_FORCE: begin
                for (int i = 0; i < 3; i++) begin
                    n_pend_force[i] = cmd[i];
                end
                n_force_wait = 1'b1;
            end
            KIND_DELTA: begin
                for (int i = 0; i < 3; i++) begin
                    n_pend_delta[i] = cmd[i];
                end
                n_delta_wait = 1'b1;
            end
            KIND_TICK: begin
                // The phase tracks floor(t * 32768 / DECAY_STEPS) with a remainder.
                if (r_elapsed < T_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                    if (rem_sum >= REM_MOD) begin
                        n_phase = r_phase + PH_STEP + 1'b1;
                        n_rem   = REM_W'(rem_sum - REM_MOD);
                    end else begin
                        n_phase = r_phase + PH_STEP;
                        n_rem   = rem_sum[REM_W-1:0];
                    end
                end
            end
            KIND_POS: begin
                if (r_init) begin
                    if (left_wall) begin
                        n_init = 1'b0;
                    end
                end else if (i_item.button) begin
                    n_held  = 1'b1;
                    produce = 1'b1;
                end else if (r_held) begin
                    n_held     = 1'b0;
                    n_push_pos = !r_push_pos;
                    n_init     = 1'b1;
                end else begin
                    produce = 1'b1;
                end

                if (produce) begin
                    if (r_force_wait) begin
                        n_force_wait = 1'b0;
                        n_elapsed    = '0;
                        n_phase      = '0;
                        n_rem        = '0;
                        for (int i = 0; i < 3; i++) begin
                            n_act_force[i] = clamp_force(r_pend_force[i]);
                        end
                    end
                    if (r_delta_wait) begin
                        n_delta_wait = 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            n_act_delta[i] = clamp_delta(r_pend_delta[i]);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_step.produce = produce;
        o_step.axis    = axis;
        o_step.in_wall = in_wall;
        o_step.pos_x   = i_item.pos_x;
        o_step.pos_y   = i_item.pos_y;
        o_step.pos_off = (POS_W + 1)'(pos_a) - (POS_W + 1)'(i_cfg.wall_position);
        o_step.phase   = n_phase;
        for (int i = 0; i < 3; i++) begin
            o_step.act_force[i] = n_act_force[i];
            o_step.act_delta[i] = n_act_delta[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init       <= 1'b1;
            r_push_pos   <= 1'b1;
            r_held       <= 1'b0;
            r_force_wait <= 1'b0;
            r_delta_wait <= 1'b0;
            r_elapsed    <= '0;
            r_phase      <= '0;
            r_rem        <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pend_force[i] <= '0;
                r_pend_delta[i] <= '0;
                r_act_force[i]  <= '0;
                r_act_delta[i]  <= '0;
            end
        end else if (i_go) begin
            r_init       <= n_init;
            r_push_pos   <= n_push_pos;
            r_held       <= n_held;
            r_force_wait <= n_force_wait;
            r_delta_wait <= n_delta_wait;
            r_elapsed    <= n_elapsed;
            r_phase      <= n_phase;
            r_rem        <= n_rem;
            for (int i = 0; i < 3; i++) begin
                r_pend_force[i] <= n_pend_force[i];
                r_pend_delta[i] <= n_pend_delta[i];
                r_act_force[i]  <= n_act_force[i];
                r_act_delta[i]  <= n_act_delta[i];
            end
        end
    end

endmodule

// ===== rtl/core/haptic_wall_force_render_top.sv =====
// Top level of the haptic wall force renderer: configuration registers,
// input register, servo state and the force arithmetic pipeline.
// Depends on hwfr_pkg, hwfr_if and hwfr_servo_ctrl.
//
// Usage: i_in carries one beat per servo event (position sample, force
// command, delta command or time tick). o_out carries one drive force beat
// for each position sample that produces a force; other beats give nothing.
// i_cfg writes stiffness, wall position and wall axis by index; it is always
// ready and should be used only while the block is idle.
// Throughput is one input beat per cycle while o_out is not stalled. A force
// beat passes from the input register, where the state update is made, into
// four arithmetic stages (products, offset and weight slope, reciprocal
// divide and weight, commanded-force product) and then through the sum and
// saturation into the output register.
// Each stage holds its beat when the stage after it is full and stalled, so a
// stall of o_out fills the empty stages before i_in.ready drops.
// Reset is synchronous and active low; it restores the configuration
// defaults, empties the pipeline and puts the servo back into initializing.
module haptic_wall_force_render_top #(
    parameter int DECAY_STEPS = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hwfr_in_if.sink      i_in,
    hwfr_out_if.source   o_out,
    hwfr_cfg_if.sink     i_cfg
);
    import hwfr_pkg::*;

    t_cfg       r_cfg;
    t_in_item   r_in;
    logic       r_in_v;
    t_step      step;
    logic       in_go;
    logic       rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage 1: products with the stiffness.
    logic                    r_v1;
    logic signed [35:0]      r1_prod_x, r1_prod_y, r1_prod_w;
    logic [1:0]              r1_axis;
    logic                    r1_inside;
    logic signed [AF_W-1:0]  r1_af [3];
    logic signed [AD_W-1:0]  r1_ad [3];
    logic [PH_W-1:0]         r1_phase;
    // Stage 2: offset dividends, wall force, weight slope.
    logic                    r_v2;
    logic [26:0]             r2_u_x, r2_u_y;
    logic signed [27:0]      r2_wall;
    logic [1:0]              r2_axis;
    logic                    r2_inside;
    logic signed [AF_W-1:0]  r2_af [3];
    logic signed [AD_W-1:0]  r2_ad [3];
    logic [WEIGHT_W-1:0]     r2_base;
    logic signed [28:0]      r2_dprod;
    // Stage 3: quotients and weight.
    logic                    r_v3;
    logic [21:0]             r3_q_x, r3_q_y;
    logic signed [27:0]      r3_wall;
    logic [1:0]              r3_axis;
    logic                    r3_inside;
    logic signed [AF_W-1:0]  r3_af [3];
    logic signed [AD_W-1:0]  r3_ad [3];
    logic [WEIGHT_W-1:0]     r3_w;
    // Stage 4: spring forces and weighted command.
    logic                    r_v4;
    logic signed [28:0]      r4_f [3];
    logic signed [29:0]      r4_afw [3];
    logic signed [AD_W-1:0]  r4_ad [3];
    // Stage 5: output register.
    logic                    r_v5;
    logic signed [FORCE_W-1:0] r5_force [3];

    // Combinational helpers.
    logic signed [16:0]      s_stiff;
    logic signed [35:0]      u_x_full, u_y_full, wall_full;
    logic [5:0]              w_idx;
    logic [WEIGHT_W-1:0]     w_next;
    logic signed [17:0]      w_diff;
    logic [54:0]             q_x_full, q_y_full;
    logic signed [28:0]      d_rnd;
    logic signed [18:0]      w_full;
    logic signed [23:0]      c_x, c_y;
    logic signed [28:0]      wall_f;
    logic signed [29:0]      afw_rnd [3];
    logic signed [29:0]      f_sum [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stiffness     <= STIFF_RESET;
            r_cfg.wall_position <= WALL_RESET;
            r_cfg.wall_axis     <= AXIS_Z;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                REG_STIFFNESS: r_cfg.stiffness     <= i_cfg.data[STIFF_W-1:0];
                REG_WALL_POS:  r_cfg.wall_position <= $signed(i_cfg.data[POS_W-1:0]);
                REG_WALL_AXIS: r_cfg.wall_axis     <= i_cfg.data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Each stage moves on when it is empty or the next one moves on.
    assign rdy5 = !r_v5 || o_out.ready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign in_go = r_in_v && rdy1;
    assign i_in.ready = !r_in_v || rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.ready) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in.kind   <= t_kind'(i_in.kind);
            r_in.pos_x  <= i_in.pos_x;
            r_in.pos_y  <= i_in.pos_y;
            r_in.pos_z  <= i_in.pos_z;
            r_in.button <= i_in.button;
            r_in.cmd_x  <= i_in.cmd_x;
            r_in.cmd_y  <= i_in.cmd_y;
            r_in.cmd_z  <= i_in.cmd_z;
        end
    end

    hwfr_servo_ctrl #(
        .DECAY_STEPS (DECAY_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (in_go),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_step  (step)
    );

    assign s_stiff = $signed({1'b0, r_cfg.stiffness});

    always_comb begin
        // Centering: floor((6400 - s*p) / 12800) via an offset dividend.
        u_x_full  = DIV_OFFSET - r1_prod_x;
        u_y_full  = DIV_OFFSET - r1_prod_y;
        wall_full = 36'sd128 - r1_prod_w;
        w_idx     = r1_phase[PH_W-1:FRAC_W];
        w_next    = weight_rom(w_idx + 6'd1);
        w_diff    = $signed({1'b0, w_next}) - $signed({1'b0, weight_rom(w_idx)});
        q_x_full  = 55'(r2_u_x) * 55'(DIV_RECIP);
        q_y_full  = 55'(r2_u_y) * 55'(DIV_RECIP);
        d_rnd     = r2_dprod + 29'sd512;
        w_full    = $signed({2'b0, r2_base}) + d_rnd[28:FRAC_W];
        c_x       = $signed({2'b0, r3_q_x}) - DIV_BIAS;
        c_y       = $signed({2'b0, r3_q_y}) - DIV_BIAS;
        wall_f    = r3_inside ? 29'(r3_wall) : 29'sd0;
        for (int i = 0; i < 3; i++) begin
            afw_rnd[i] = r4_afw[i] + 30'sd16384;
            f_sum[i]   = 30'(r4_f[i]) + 30'($signed(afw_rnd[i][29:15])) + 30'(r4_ad[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= in_go && step.produce;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_prod_x <= 36'(s_stiff) * 36'(step.pos_x);
            r1_prod_y <= 36'(s_stiff) * 36'(step.pos_y);
            r1_prod_w <= 36'(s_stiff) * 36'(step.pos_off);
            r1_axis   <= step.axis;
            r1_inside <= step.in_wall;
            r1_phase  <= step.phase;
            for (int i = 0; i < 3; i++) begin
                r1_af[i] <= $signed(step.act_force[i]);
                r1_ad[i] <= $signed(step.act_delta[i]);
            end
        end
        if (rdy2) begin
            r2_u_x    <= u_x_full[34:8];
            r2_u_y    <= u_y_full[34:8];
            r2_wall   <= wall_full[35:8];
            r2_axis   <= r1_axis;
            r2_inside <= r1_inside;
            r2_base   <= weight_rom(w_idx);
            r2_dprod  <= 29'(w_diff) * 29'($signed({1'b0, r1_phase[FRAC_W-1:0]}));
            for (int i = 0; i < 3; i++) begin
                r2_af[i] <= r1_af[i];
                r2_ad[i] <= r1_ad[i];
            end
        end
        if (rdy3) begin
            r3_q_x    <= q_x_full[54:DIV_SHIFT];
            r3_q_y    <= q_y_full[54:DIV_SHIFT];
            r3_wall   <= r2_wall;
            r3_axis   <= r2_axis;
            r3_inside <= r2_inside;
            r3_w      <= w_full[WEIGHT_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r3_af[i] <= r2_af[i];
                r3_ad[i] <= r2_ad[i];
            end
        end
        if (rdy4) begin
            // The wall axis loses its centering spring and takes the wall force.
            case (r3_axis)
                AXIS_X: begin
                    r4_f[0] <= wall_f;
                    r4_f[1] <= 29'(c_y);
                    r4_f[2] <= 29'sd0;
                end
                AXIS_Y: begin
                    r4_f[0] <= 29'(c_x);
                    r4_f[1] <= wall_f;
                    r4_f[2] <= 29'sd0;
                end
                default: begin
                    r4_f[0] <= 29'(c_x);
                    r4_f[1] <= 29'(c_y);
                    r4_f[2] <= wall_f;
                end
            endcase
            for (int i = 0; i < 3; i++) begin
                r4_afw[i] <= 30'(r3_af[i]) * 30'($signed({1'b0, r3_w}));
                r4_ad[i]  <= r3_ad[i];
            end
        end
        if (rdy5) begin
            for (int i = 0; i < 3; i++) begin
                if (f_sum[i] > 30'sd32767) begin
                    r5_force[i] <= 16'sh7FFF;
                end else if (f_sum[i] < -30'sd32768) begin
                    r5_force[i] <= 16'sh8000;
                end else begin
                    r5_force[i] <= f_sum[i][FORCE_W-1:0];
                end
            end
        end
    end

    assign o_out.valid   = r_v5;
    assign o_out.force_x = r5_force[0];
    assign o_out.force_y = r5_force[1];
    assign o_out.force_z = r5_force[2];

endmodule
